### hdl/irf_pkg.sv
// Types, character codes and digit lookup shared by the integer radix formatter.
`timescale 1ns / 1ps

package irf_pkg;

    localparam int POS_W = 7;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_UP_X  = 8'h58;
    localparam logic [7:0] CH_LO_X  = 8'h78;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_HEX = 6'd16;
    localparam logic [5:0] DEC_DIGITS = 6'd10;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DIV   = 5'b00010,
        ST_SETUP = 5'b00100,
        ST_EMIT  = 5'b01000,
        ST_BAD   = 5'b10000
    } state_t;

    // digit value (below 36) to ASCII
    function automatic logic [7:0] digit_char(input logic [5:0] v, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UP_A : CH_LO_A;
            if (v < DEC_DIGITS)
            begin
                digit_char = CH_ZERO + {2'b00, v};
            end
            else
            begin
                digit_char = base + {2'b00, v} - {2'b00, DEC_DIGITS};
            end
        end
    endfunction

endpackage

### hdl/integer_radix_formatter.sv
// Top level: printf-style integer to ASCII field conversion in radix 2 to 36.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata: value, radix, min_width, min_digits, flags
//  m_      | out | m_tvalid/m_tready  | m_tdata: character; m_tlast: last; m_tuser: bad_radix
//
// One bit-serial restoring divide step per cycle sets the digit time; then one
// character per cycle from the output register, unless m_tready stalls it.
// Reset clears the sequencer and the output valid; payload registers are not reset.
// m_tready low holds a pending character and stalls character emission (the divide
// steps do not stall); s_tready is high only when idle.
`timescale 1ns / 1ps

module integer_radix_formatter
    import irf_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 63
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] value, [37:32] radix, [43:38] min_width, [49:44] min_digits,
    // [50] left_justify, [51] zero_pad, [52] signed_mode, [53] show_plus,
    // [54] space_sign, [55] alt_prefix, [56] upper_case, [63:57] zero
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] character
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // [0] bad_radix
    output logic        m_tuser
);

    localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam int ND_W  = $clog2(VALUE_BITS + 1);
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FIELD);

    // input fields
    logic [VALUE_BITS-1:0] in_value;
    logic [5:0]            in_radix;
    logic [5:0]            in_width;
    logic [5:0]            in_prec;
    logic                  in_left;
    logic                  in_zpad;
    logic                  in_sgn;
    logic                  in_plus;
    logic                  in_space;
    logic                  in_alt;
    logic                  in_upper;

    assign in_value = s_tdata[VALUE_BITS-1:0];
    assign in_radix = s_tdata[37:32];
    assign in_width = s_tdata[43:38];
    assign in_prec  = s_tdata[49:44];
    assign in_left  = s_tdata[50];
    assign in_zpad  = s_tdata[51];
    assign in_sgn   = s_tdata[52];
    assign in_plus  = s_tdata[53];
    assign in_space = s_tdata[54];
    assign in_alt   = s_tdata[55];
    assign in_upper = s_tdata[56];

    state_t                state_reg, state_next;

    logic [VALUE_BITS-1:0] num_reg, num_next;
    logic [5:0]            rem_reg, rem_next;
    logic [CNT_W-1:0]      bcnt_reg, bcnt_next;
    logic [ND_W-1:0]       nd_reg, nd_next;
    logic [5:0]            digits_reg [VALUE_BITS];

    logic [5:0]            radix_reg;
    logic [5:0]            width_reg;
    logic [5:0]            prec_reg;
    logic                  left_reg;
    logic                  zpad_reg;
    logic                  upper_reg;
    logic                  has_sign_reg;
    logic [7:0]            sign_char_reg;
    logic [1:0]            prefix_reg;

    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      b_lead_reg, b_sign_reg, b_pre_reg, b_prec_reg, b_dig_reg;
    logic [POS_W-1:0]      last_pos_reg;

    logic                  m_tvalid_reg, m_tvalid_next;
    logic [7:0]            m_tdata_reg;
    logic                  m_tlast_reg;
    logic                  m_tuser_reg;

    logic                  accept;
    logic                  out_free;
    logic                  radix_bad;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;

    logic [6:0]            trial;
    logic                  ge;
    logic                  digit_done;

    logic [POS_W-1:0]      nd_ext, prec_ext, prec_eff, base_len, pad_len, total_len, total_clip;
    logic                  right_spaces;

    logic [POS_W-1:0]      dig_off;
    logic [7:0]            x_char;
    logic [7:0]            emit_char;

    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign radix_bad = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
    assign neg       = in_sgn && in_value[VALUE_BITS-1];
    assign mag       = neg ? (VALUE_BITS'(0) - in_value) : in_value;

    // shared divide step
    assign trial      = {rem_reg, num_reg[VALUE_BITS-1]};
    assign ge         = trial >= {1'b0, radix_reg};
    assign rem_next   = ge ? 6'(trial - {1'b0, radix_reg}) : trial[5:0];
    assign digit_done = (bcnt_reg == '0);

    // field geometry
    assign nd_ext       = POS_W'(nd_reg);
    assign prec_ext     = POS_W'(prec_reg);
    assign prec_eff     = (nd_ext > prec_ext) ? nd_ext : prec_ext;
    assign base_len     = POS_W'(has_sign_reg) + POS_W'(prefix_reg) + prec_eff;
    assign pad_len      = (POS_W'(width_reg) > base_len) ? (POS_W'(width_reg) - base_len) : '0;
    assign total_len    = base_len + pad_len;
    assign total_clip   = (total_len > MAX_POS) ? MAX_POS : total_len;
    assign right_spaces = !zpad_reg && !left_reg;

    // character at the current position
    assign dig_off = b_dig_reg - pos_reg - POS_W'(1);
    assign x_char  = upper_reg ? CH_UP_X : CH_LO_X;

    always_comb
    begin
        if (pos_reg < b_lead_reg)
        begin
            emit_char = CH_SPACE;
        end
        else if (pos_reg < b_sign_reg)
        begin
            emit_char = sign_char_reg;
        end
        else if (pos_reg < b_pre_reg)
        begin
            emit_char = (pos_reg == b_sign_reg) ? CH_ZERO : x_char;
        end
        else if (pos_reg < b_prec_reg)
        begin
            emit_char = CH_ZERO;
        end
        else if (pos_reg < b_dig_reg)
        begin
            emit_char = digit_char(digits_reg[dig_off[CNT_W-1:0]], upper_reg);
        end
        else
        begin
            emit_char = CH_SPACE;
        end
    end

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        num_next      = num_reg;
        bcnt_next     = bcnt_reg;
        nd_next       = nd_reg;
        pos_next      = pos_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next   = mag;
                    bcnt_next  = CNT_W'(VALUE_BITS - 1);
                    nd_next    = '0;
                    state_next = radix_bad ? ST_BAD : ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next  = {num_reg[VALUE_BITS-2:0], ge};
                bcnt_next = bcnt_reg - CNT_W'(1);
                if (digit_done)
                begin
                    nd_next   = nd_reg + ND_W'(1);
                    bcnt_next = CNT_W'(VALUE_BITS - 1);
                    if (num_next == '0)
                    begin
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP:
            begin
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    pos_next      = pos_reg + POS_W'(1);
                    if (pos_reg == last_pos_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_BAD:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bcnt_reg     <= '0;
            nd_reg       <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            bcnt_reg     <= bcnt_next;
            nd_reg       <= nd_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        if (accept)
        begin
            radix_reg     <= in_radix;
            width_reg     <= in_width;
            prec_reg      <= in_prec;
            left_reg      <= in_left;
            zpad_reg      <= in_zpad && !in_left;
            upper_reg     <= in_upper;
            has_sign_reg  <= in_sgn && (in_value[VALUE_BITS-1] || in_plus || in_space);
            sign_char_reg <= in_value[VALUE_BITS-1] ? CH_MINUS : (in_plus ? CH_PLUS : CH_SPACE);
            prefix_reg    <= !in_alt ? 2'd0 : (in_radix == RADIX_HEX) ? 2'd2 :
                             (in_radix == RADIX_OCT) ? 2'd1 : 2'd0;
            rem_reg       <= '0;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg <= digit_done ? 6'd0 : rem_next;
            if (digit_done)
            begin
                digits_reg[nd_reg[CNT_W-1:0]] <= rem_next;
            end
        end
        if (state_reg == ST_SETUP)
        begin
            b_lead_reg   <= right_spaces ? pad_len : '0;
            b_sign_reg   <= (right_spaces ? pad_len : '0) + POS_W'(has_sign_reg);
            b_pre_reg    <= (right_spaces ? pad_len : '0) + POS_W'(has_sign_reg) +
                            POS_W'(prefix_reg);
            b_prec_reg   <= (right_spaces ? pad_len : '0) + POS_W'(has_sign_reg) +
                            POS_W'(prefix_reg) + (zpad_reg ? pad_len : '0) + prec_eff - nd_ext;
            b_dig_reg    <= (right_spaces ? pad_len : '0) + POS_W'(has_sign_reg) +
                            POS_W'(prefix_reg) + (zpad_reg ? pad_len : '0) + prec_eff;
            last_pos_reg <= total_clip - POS_W'(1);
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            m_tdata_reg <= emit_char;
            m_tlast_reg <= (pos_reg == last_pos_reg);
            m_tuser_reg <= 1'b0;
        end
        else if (state_reg == ST_BAD && out_free)
        begin
            m_tdata_reg <= CH_NUL;
            m_tlast_reg <= 1'b1;
            m_tuser_reg <= 1'b1;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("accepted a second item while busy");

    a_bad_item_form: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == CH_NUL))
        else $error("bad radix item malformed");

    a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= ND_W'(VALUE_BITS))
        else $error("digit count overrun");

    a_emit_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (pos_reg <= last_pos_reg && last_pos_reg < MAX_POS))
        else $error("character position beyond field");

endmodule
